// ===== design/ows_pkg.sv =====
// Shared types and constants of the 1-Wire ROM search engine.
// Used by every design file but ows_if through scoped names; depends on nothing.

package ows_pkg;

   localparam int RomBits     = 64;
   localparam int PosWidth    = 7;
   localparam int FamPosWidth = 4;

   localparam logic [PosWidth-1:0] POS_NONE      = 7'd0;
   localparam logic [PosWidth-1:0] POS_FIRST     = 7'd1;
   localparam logic [PosWidth-1:0] POS_LAST      = 7'd64;
   localparam logic [PosWidth-1:0] FAMILY_LIMIT  = 7'd9;

   typedef enum logic [1:0] {
      OP_RESTART = 2'd0,
      OP_TARGET  = 2'd1,
      OP_BEGIN   = 2'd2,
      OP_PAIR    = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_ACK     = 3'd0,
      ST_STARTED = 3'd1,
      ST_WRITE   = 3'd2,
      ST_FOUND   = 3'd3,
      ST_NONE    = 3'd4
   } status_type;

   typedef struct packed {
      op_type     operation;
      logic       presence;
      logic       id_bit;
      logic       comp_bit;
      logic [7:0] target_family;
   } req_type;

   typedef struct packed {
      status_type             status;
      logic                   direction;
      logic [RomBits-1:0]     rom_code;
      logic [FamPosWidth-1:0] family_mismatch_pos;
      logic                   was_last_device;
   } rsp_type;

   typedef struct packed {
      logic [RomBits-1:0]     rom_bits;
      logic [PosWidth-1:0]    discrepancy_pos;
      logic [FamPosWidth-1:0] family_pos;
      logic                   last_found;
      logic [PosWidth-1:0]    bit_position;
      logic [PosWidth-1:0]    zero_choice_pos;
      logic                   pass_active;
   } state_type;

endpackage

// ===== design/ows_if.sv =====
// Valid/ready channel interfaces of the 1-Wire ROM search engine.
// Request and response words; no dependencies.

interface ows_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] operation;
   logic       presence;
   logic       id_bit;
   logic       comp_bit;
   logic [7:0] target_family;

   modport source (output valid, operation, presence, id_bit, comp_bit, target_family,
                   input ready);
   modport sink   (input valid, operation, presence, id_bit, comp_bit, target_family,
                   output ready);
endinterface

interface ows_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic        direction;
   logic [63:0] rom_code;
   logic [3:0]  family_mismatch_pos;
   logic        was_last_device;

   modport source (output valid, status, direction, rom_code, family_mismatch_pos,
                   was_last_device, input ready);
   modport sink   (input valid, status, direction, rom_code, family_mismatch_pos,
                   was_last_device, output ready);
endinterface

// ===== design/ows_in_stage.sv =====
// Input register of the ROM search engine: holds one request word.
// Depends on ows_pkg and ows_req_if.

module ows_in_stage (
   input  logic              clock,
   input  logic              reset,
   ows_req_if.sink           req_chan,
   input  logic              take,
   output logic              in_valid,
   output ows_pkg::req_type  in_data
);

   logic              valid_ff, valid_in;
   ows_pkg::req_type  data_ff, data_in;
   logic              accept;

   // The register can load whenever it is empty or its word moves on this cycle.
   assign req_chan.ready = !valid_ff || take;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (accept) begin
         valid_in               = 1'b1;
         data_in.operation      = ows_pkg::op_type'(req_chan.operation);
         data_in.presence       = req_chan.presence;
         data_in.id_bit         = req_chan.id_bit;
         data_in.comp_bit       = req_chan.comp_bit;
         data_in.target_family  = req_chan.target_family;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign in_valid = valid_ff;
   assign in_data  = data_ff;

endmodule

// ===== design/ows_step.sv =====
// Next-state and result logic of the ROM search for one request word.
// Depends on ows_pkg.

module ows_step (
   input  ows_pkg::req_type    item,
   input  ows_pkg::state_type  state_cur,
   output ows_pkg::state_type  state_nxt,
   output ows_pkg::rsp_type    result
);

   ows_pkg::state_type  nxt;
   ows_pkg::status_type status;
   logic                dir;
   logic [5:0]          idx;

   // Bit position runs 1..64; position 64 wraps to index 63.
   assign idx = state_cur.bit_position[5:0] - 6'd1;

   always_comb begin
      nxt    = state_cur;
      status = ows_pkg::ST_ACK;
      dir    = 1'b0;
      unique case (item.operation)
         ows_pkg::OP_RESTART: begin
            nxt.rom_bits        = '0;
            nxt.discrepancy_pos = ows_pkg::POS_NONE;
            nxt.family_pos      = '0;
            nxt.last_found      = 1'b0;
            nxt.pass_active     = 1'b0;
            nxt.bit_position    = ows_pkg::POS_FIRST;
            nxt.zero_choice_pos = ows_pkg::POS_NONE;
         end
         ows_pkg::OP_TARGET: begin
            nxt.rom_bits        = {{(ows_pkg::RomBits-8){1'b0}}, item.target_family};
            nxt.discrepancy_pos = ows_pkg::POS_LAST;
            nxt.family_pos      = '0;
            nxt.last_found      = 1'b0;
            nxt.pass_active     = 1'b0;
            nxt.bit_position    = ows_pkg::POS_FIRST;
            nxt.zero_choice_pos = ows_pkg::POS_NONE;
         end
         ows_pkg::OP_BEGIN: begin
            nxt.bit_position    = ows_pkg::POS_FIRST;
            nxt.zero_choice_pos = ows_pkg::POS_NONE;
            if (state_cur.last_found || !item.presence) begin
               nxt.discrepancy_pos = ows_pkg::POS_NONE;
               nxt.family_pos      = '0;
               nxt.last_found      = 1'b0;
               nxt.pass_active     = 1'b0;
               status              = ows_pkg::ST_NONE;
            end else begin
               nxt.pass_active = 1'b1;
               status          = ows_pkg::ST_STARTED;
            end
         end
         ows_pkg::OP_PAIR: begin
            if (state_cur.pass_active) begin
               if (item.id_bit && item.comp_bit) begin
                  // Nobody answered this slot pair: the pass is dropped.
                  nxt.discrepancy_pos = ows_pkg::POS_NONE;
                  nxt.family_pos      = '0;
                  nxt.last_found      = 1'b0;
                  nxt.pass_active     = 1'b0;
                  nxt.bit_position    = ows_pkg::POS_FIRST;
                  status              = ows_pkg::ST_NONE;
               end else begin
                  if (item.id_bit != item.comp_bit) begin
                     dir = item.id_bit;
                  end else begin
                     // Discrepancy: follow the previous path below the last
                     // discrepancy, take 1 at it and 0 beyond it.
                     if (state_cur.bit_position < state_cur.discrepancy_pos) begin
                        dir = state_cur.rom_bits[idx];
                     end else begin
                        dir = (state_cur.bit_position == state_cur.discrepancy_pos);
                     end
                     if (!dir) begin
                        nxt.zero_choice_pos = state_cur.bit_position;
                        if (state_cur.bit_position < ows_pkg::FAMILY_LIMIT) begin
                           nxt.family_pos = state_cur.bit_position[3:0];
                        end
                     end
                  end
                  nxt.rom_bits[idx] = dir;
                  if (state_cur.bit_position >= ows_pkg::POS_LAST) begin
                     nxt.pass_active     = 1'b0;
                     nxt.bit_position    = ows_pkg::POS_FIRST;
                     nxt.discrepancy_pos = nxt.zero_choice_pos;
                     if (nxt.zero_choice_pos == ows_pkg::POS_NONE) begin
                        nxt.last_found = 1'b1;
                     end
                     if (nxt.rom_bits[7:0] == 8'd0) begin
                        nxt.discrepancy_pos = ows_pkg::POS_NONE;
                        nxt.family_pos      = '0;
                        nxt.last_found      = 1'b0;
                        status              = ows_pkg::ST_NONE;
                     end else begin
                        status = ows_pkg::ST_FOUND;
                     end
                  end else begin
                     nxt.bit_position = state_cur.bit_position + 7'd1;
                     status           = ows_pkg::ST_WRITE;
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign state_nxt                  = nxt;
   assign result.status              = status;
   assign result.direction           = dir;
   assign result.rom_code            = nxt.rom_bits;
   assign result.family_mismatch_pos = nxt.family_pos;
   assign result.was_last_device     = nxt.last_found;

endmodule

// ===== design/ows_out_stage.sv =====
// Result register of the ROM search engine: holds one response word.
// Depends on ows_pkg and ows_rsp_if.

module ows_out_stage (
   input  logic              clock,
   input  logic              reset,
   ows_rsp_if.source         rsp_chan,
   input  logic              load,
   input  ows_pkg::rsp_type  load_data,
   output logic              can_load
);

   logic              valid_ff, valid_in;
   ows_pkg::rsp_type  data_ff, data_in;

   // A new word may enter when the register is empty or its word leaves now.
   assign can_load = !valid_ff || rsp_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = load_data;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_chan.valid               = valid_ff;
   assign rsp_chan.status              = data_ff.status;
   assign rsp_chan.direction           = data_ff.direction;
   assign rsp_chan.rom_code            = data_ff.rom_code;
   assign rsp_chan.family_mismatch_pos = data_ff.family_mismatch_pos;
   assign rsp_chan.was_last_device     = data_ff.was_last_device;

endmodule

// ===== design/onewire_rom_search_top.sv =====
// Top level of the 1-Wire ROM search engine.
// Depends on ows_pkg, ows_if, ows_in_stage, ows_step and ows_out_stage.

// The engine takes one request word per clock (restart, family restart, start
// of pass, or one id/complement bit pair) and returns exactly one response word
// for each, in order. An accepted request is held in the request register, and
// its response enters the response register once it can load. Throughput is
// one word per cycle as long as the response side takes words; a request register
// and a response register each hold one word, so one stalled response does not
// stop the next request from being taken. The search memory (ROM code, last
// discrepancy, family discrepancy, last-device flag, bit position) is updated
// by combinational logic between those two registers. Bus slot timing, the search
// command write and the CRC check are left to the surrounding logic.

module onewire_rom_search_top (
   input  logic        clock,
   input  logic        reset,
   ows_req_if.sink     req_chan,
   ows_rsp_if.source   rsp_chan
);

   logic                in_valid;
   ows_pkg::req_type    in_data;
   logic                can_load;
   logic                advance;
   ows_pkg::state_type  state_ff, state_in;
   ows_pkg::rsp_type    step_result;

   assign advance = in_valid && can_load;

   ows_in_stage u_in_stage (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .take     (advance),
      .in_valid (in_valid),
      .in_data  (in_data)
   );

   ows_step u_step (
      .item      (in_data),
      .state_cur (state_ff),
      .state_nxt (state_in),
      .result    (step_result)
   );

   ows_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .rsp_chan  (rsp_chan),
      .load      (advance),
      .load_data (step_result),
      .can_load  (can_load)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.rom_bits        <= '0;
         state_ff.discrepancy_pos <= ows_pkg::POS_NONE;
         state_ff.family_pos      <= '0;
         state_ff.last_found      <= 1'b0;
         state_ff.bit_position    <= ows_pkg::POS_FIRST;
         state_ff.zero_choice_pos <= ows_pkg::POS_NONE;
         state_ff.pass_active     <= 1'b0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // The bit position always names a bit of the ROM code.
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.bit_position != ows_pkg::POS_NONE &&
      state_ff.bit_position <= ows_pkg::POS_LAST)
      else $error("bit position out of range");

   // Outside a pass the position is parked at the first bit.
   a_idle_pos: assert property (@(posedge clock) disable iff (reset)
      !state_ff.pass_active |-> state_ff.bit_position == ows_pkg::POS_FIRST)
      else $error("bit position not parked outside a pass");

   // The family discrepancy lies inside the family byte.
   a_family_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.family_pos < ows_pkg::FAMILY_LIMIT[3:0])
      else $error("family discrepancy beyond family byte");

   // A bit pair outside a pass leaves the ROM code alone.
   a_stray_pair: assert property (@(posedge clock) disable iff (reset)
      advance && in_data.operation == ows_pkg::OP_PAIR && !state_ff.pass_active
      |=> $stable(state_ff.rom_bits))
      else $error("bit pair outside a pass changed the ROM code");

   // A word that moves on is in the response register next cycle.
   a_moves_out: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_chan.valid)
      else $error("response word lost");

endmodule
